// File: sv/cbb_pkg.sv
// Shared types and constants of the clipped box blur.
package cbb_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_RADIUS  = 7;

  localparam int POS_W       = 6;
  localparam int DIM_W       = 7;
  localparam int RAD_W       = 3;
  localparam int PIXEL_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int CHANNELS    = PIXEL_W / CHAN_W;
  localparam int SPAN_W      = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W       = 2 * SPAN_W;
  localparam int SUM_W       = CHAN_W + CNT_W;
  localparam int STEP_W      = $clog2(CHAN_W);
  localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [POS_W-1:0]   x_position;
    logic [POS_W-1:0]   y_position;
    logic [PIXEL_W-1:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] mean_pixel;
    logic               bad_coordinate;
  } result_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [POS_W-1:0]   x0;
    logic [POS_W-1:0]   x1;
    logic [POS_W-1:0]   y0;
    logic [POS_W-1:0]   y1;
    logic [CNT_W-1:0]   count;
    logic [PIXEL_W-1:0] pixel;
  } cmd_t;

endpackage

// File: sv/cbb_front.sv
// Front end: configuration registers, word acceptance and window clipping.
module cbb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  cbb_pkg::item_t                  item,
  input  logic                            cfg_write,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            queue_full,
  output logic                            push,
  output cbb_pkg::cmd_t                   cmd
);

  logic [cbb_pkg::DIM_W-1:0]  image_width;
  logic [cbb_pkg::DIM_W-1:0]  image_height;
  logic [cbb_pkg::RAD_W-1:0]  blur_radius;

  logic [cbb_pkg::DIM_W-1:0]  w_eff;
  logic [cbb_pkg::DIM_W-1:0]  h_eff;
  logic [cbb_pkg::RAD_W-1:0]  r_eff;
  logic [cbb_pkg::DIM_W-1:0]  x_ext;
  logic [cbb_pkg::DIM_W-1:0]  y_ext;
  logic [cbb_pkg::DIM_W-1:0]  x_hi;
  logic [cbb_pkg::DIM_W-1:0]  y_hi;
  logic [cbb_pkg::DIM_W-1:0]  x_lim;
  logic [cbb_pkg::DIM_W-1:0]  y_lim;
  logic [cbb_pkg::POS_W-1:0]  x0;
  logic [cbb_pkg::POS_W-1:0]  x1;
  logic [cbb_pkg::POS_W-1:0]  y0;
  logic [cbb_pkg::POS_W-1:0]  y1;
  logic [cbb_pkg::SPAN_W-1:0] span_x;
  logic [cbb_pkg::SPAN_W-1:0] span_y;
  logic                       bad;
  logic                       in_store;
  logic                       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= cbb_pkg::WIDTH_RESET;
      image_height <= cbb_pkg::HEIGHT_RESET;
      blur_radius  <= cbb_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cbb_pkg::CFG_WIDTH:  image_width  <= cfg_data;
        cbb_pkg::CFG_HEIGHT: image_height <= cfg_data;
        cbb_pkg::CFG_RADIUS: blur_radius  <= cfg_data[cbb_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (int'(image_width) > cbb_pkg::MAX_WIDTH) ?
            cbb_pkg::DIM_W'(cbb_pkg::MAX_WIDTH) : image_width;
    h_eff = (int'(image_height) > cbb_pkg::MAX_HEIGHT) ?
            cbb_pkg::DIM_W'(cbb_pkg::MAX_HEIGHT) : image_height;
    r_eff = (int'(blur_radius) > cbb_pkg::MAX_RADIUS) ?
            cbb_pkg::RAD_W'(cbb_pkg::MAX_RADIUS) : blur_radius;

    x_ext = cbb_pkg::DIM_W'(item.x_position);
    y_ext = cbb_pkg::DIM_W'(item.y_position);
    bad   = (x_ext >= w_eff) || (y_ext >= h_eff);

    x0 = (item.x_position > cbb_pkg::POS_W'(r_eff)) ?
         item.x_position - cbb_pkg::POS_W'(r_eff) : '0;
    y0 = (item.y_position > cbb_pkg::POS_W'(r_eff)) ?
         item.y_position - cbb_pkg::POS_W'(r_eff) : '0;
    x_hi  = x_ext + cbb_pkg::DIM_W'(r_eff);
    y_hi  = y_ext + cbb_pkg::DIM_W'(r_eff);
    x_lim = w_eff - 1'b1;
    y_lim = h_eff - 1'b1;
    x1 = cbb_pkg::POS_W'((x_hi > x_lim) ? x_lim : x_hi);
    y1 = cbb_pkg::POS_W'((y_hi > y_lim) ? y_lim : y_hi);
    span_x = cbb_pkg::SPAN_W'(x1 - x0 + 1'b1);
    span_y = cbb_pkg::SPAN_W'(y1 - y0 + 1'b1);

    in_store = (int'(item.x_position) < cbb_pkg::MAX_WIDTH) &&
               (int'(item.y_position) < cbb_pkg::MAX_HEIGHT);

    cmd.x0    = x0;
    cmd.x1    = x1;
    cmd.y0    = y0;
    cmd.y1    = y1;
    cmd.count = cbb_pkg::CNT_W'(span_x) * cbb_pkg::CNT_W'(span_y);
    cmd.pixel = item.pixel_value;
    if (item.operation == cbb_pkg::OP_WRITE) begin
      cmd.kind = cbb_pkg::CMD_WRITE;
      cmd.x0   = item.x_position;
      cmd.y0   = item.y_position;
    end else if (bad) begin
      cmd.kind = cbb_pkg::CMD_BAD;
    end else begin
      cmd.kind = cbb_pkg::CMD_QUERY;
    end

    busy   = queue_full;
    accept = start && !queue_full;
    push   = accept && ((item.operation == cbb_pkg::OP_QUERY) || in_store);
  end

endmodule

// File: sv/cbb_queue.sv
// Short command queue between the front end and the back end.
module cbb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbb_pkg::cmd_t push_cmd,
  input  logic          pop,
  output cbb_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  cbb_pkg::cmd_t                entries [cbb_pkg::QUEUE_DEPTH];
  logic [cbb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cbb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cbb_pkg::QFILL_W-1:0]  fill;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (fill == cbb_pkg::QFILL_W'(cbb_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == cbb_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == cbb_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: sv/cbb_back.sv
// Back end: image memory, window accumulation and per-channel division.
module cbb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  cbb_pkg::cmd_t    head,
  output logic             pop,
  output logic             done,
  output cbb_pkg::result_t result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV
  } state_t;

  state_t                       state;
  logic [cbb_pkg::POS_W-1:0]    cx;
  logic [cbb_pkg::POS_W-1:0]    cy;
  logic [cbb_pkg::POS_W-1:0]    x0;
  logic [cbb_pkg::POS_W-1:0]    x1;
  logic [cbb_pkg::POS_W-1:0]    y1;
  logic [cbb_pkg::CNT_W-1:0]    count;
  logic [cbb_pkg::SUM_W-1:0]    sums [cbb_pkg::CHANNELS];
  logic [cbb_pkg::CHAN_W-1:0]   quot [cbb_pkg::CHANNELS];
  logic [cbb_pkg::STEP_W-1:0]   step;
  logic                         rd_valid;

  logic [cbb_pkg::PIXEL_W-1:0]  mem [cbb_pkg::MAX_WIDTH * cbb_pkg::MAX_HEIGHT];
  logic [cbb_pkg::PIXEL_W-1:0]  rd_data;
  logic [cbb_pkg::ADDR_W-1:0]   rd_addr;
  logic [cbb_pkg::ADDR_W-1:0]   wr_addr;
  logic                         mem_we;

  logic [cbb_pkg::SUM_W-1:0]    trial;
  logic [cbb_pkg::SUM_W-1:0]    rem_next  [cbb_pkg::CHANNELS];
  logic [cbb_pkg::CHAN_W-1:0]   quot_next [cbb_pkg::CHANNELS];
  logic [cbb_pkg::PIXEL_W-1:0]  packed_q;

  assign pop     = (state == ST_IDLE) && !empty;
  assign mem_we  = pop && (head.kind == cbb_pkg::CMD_WRITE);
  assign wr_addr = cbb_pkg::ADDR_W'(head.y0) * cbb_pkg::ADDR_W'(cbb_pkg::MAX_WIDTH)
                 + cbb_pkg::ADDR_W'(head.x0);
  assign rd_addr = cbb_pkg::ADDR_W'(cy) * cbb_pkg::ADDR_W'(cbb_pkg::MAX_WIDTH)
                 + cbb_pkg::ADDR_W'(cx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= head.pixel;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    trial = cbb_pkg::SUM_W'(count) << step;
    for (int ch = 0; ch < cbb_pkg::CHANNELS; ch++) begin
      rem_next[ch]  = sums[ch];
      quot_next[ch] = quot[ch];
      if (sums[ch] >= trial) begin
        rem_next[ch]        = sums[ch] - trial;
        quot_next[ch][step] = 1'b1;
      end
      packed_q[ch*cbb_pkg::CHAN_W +: cbb_pkg::CHAN_W] = quot_next[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= (state == ST_READ);
      if (rd_valid) begin
        for (int ch = 0; ch < cbb_pkg::CHANNELS; ch++) begin
          sums[ch] <= sums[ch]
                    + cbb_pkg::SUM_W'(rd_data[ch*cbb_pkg::CHAN_W +: cbb_pkg::CHAN_W]);
        end
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            case (head.kind)
              cbb_pkg::CMD_BAD: begin
                result.mean_pixel     <= '0;
                result.bad_coordinate <= 1'b1;
                done                  <= 1'b1;
              end
              cbb_pkg::CMD_QUERY: begin
                cx    <= head.x0;
                cy    <= head.y0;
                x0    <= head.x0;
                x1    <= head.x1;
                y1    <= head.y1;
                count <= head.count;
                for (int ch = 0; ch < cbb_pkg::CHANNELS; ch++) begin
                  sums[ch] <= '0;
                end
                state <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (cx == x1) begin
            cx <= x0;
            if (cy == y1) begin
              state <= ST_DRAIN;
            end else begin
              cy <= cy + 1'b1;
            end
          end else begin
            cx <= cx + 1'b1;
          end
        end
        ST_DRAIN: begin
          step <= cbb_pkg::STEP_W'(cbb_pkg::CHAN_W - 1);
          for (int ch = 0; ch < cbb_pkg::CHANNELS; ch++) begin
            quot[ch] <= '0;
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          for (int ch = 0; ch < cbb_pkg::CHANNELS; ch++) begin
            sums[ch] <= rem_next[ch];
            quot[ch] <= quot_next[ch];
          end
          if (step == '0) begin
            result.mean_pixel     <= packed_q;
            result.bad_coordinate <= 1'b0;
            done                  <= 1'b1;
            state                 <= ST_IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/clipped_box_blur.sv
// Top level of the clipped box blur: front end, command queue and back end.
// A word is taken when start is high and busy is low; busy rises only while
// the two-entry command queue is full. The back end takes a pixel write or a
// query outside the image straight from the queue; a good query reads each
// pixel of its clipped window (up to 225, one read a cycle from the single
// read port of the image memory), then drains the read and runs the
// eight-step division; the next command leaves the queue only after that
// result. Each result is shown for one cycle with done high and cannot be
// held off. The image memory is not cleared after reset; a pixel must be
// written before a query window covers it.
module clipped_box_blur (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  cbb_pkg::item_t                  item,
  input  logic                            cfg_write,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output cbb_pkg::result_t                result
);

  cbb_pkg::cmd_t front_cmd;
  cbb_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  cbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (full),
    .push       (push),
    .cmd        (front_cmd)
  );

  cbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  cbb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
